/* rtl/u8d_pkg.sv */
// Package: shared types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 31;
  localparam int unsigned LenW  = 3;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_TRUNC   = 2'd2
  } status_t;

  // Sequence-in-progress state
  typedef struct packed {
    logic [LenW-1:0]  pending;   // continuation bytes still expected, 0 = idle
    logic [CodeW-1:0] partial;   // code bits gathered so far
    logic [LenW-1:0]  total;     // length of the sequence in progress
  } dec_state_t;

  // One decode result
  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
    status_t          status;
  } dec_result_t;

  localparam dec_state_t StateIdle = '{pending: '0, partial: '0, total: '0};

endpackage

/* rtl/u8d_step.sv */
// Combinational decode step: one byte plus current state gives next state and result.
`timescale 1ns / 1ps

module u8d_step (
  input  logic [u8d_pkg::ByteW-1:0] byte_i,
  input  u8d_pkg::dec_state_t       state_i,
  output u8d_pkg::dec_state_t       state_o,
  output u8d_pkg::dec_result_t      res_o
);

  logic [u8d_pkg::CodeW-1:0] shifted;

  // Partial code shifted by one continuation byte
  assign shifted = {state_i.partial[u8d_pkg::CodeW-7:0], byte_i[5:0]};

  always_comb begin
    state_o = state_i;
    res_o   = '{valid: 1'b0, code: '0, len: '0, status: u8d_pkg::ST_OK};

    if (state_i.pending != '0) begin
      // Inside a sequence: zero byte truncates, anything else continues
      if (byte_i == '0) begin
        state_o = u8d_pkg::StateIdle;
        res_o   = '{valid: 1'b1, code: '0, len: '0, status: u8d_pkg::ST_TRUNC};
      end else if (state_i.pending == u8d_pkg::LenW'(1)) begin
        state_o = u8d_pkg::StateIdle;
        res_o   = '{valid: 1'b1, code: shifted, len: state_i.total,
                    status: u8d_pkg::ST_OK};
      end else begin
        state_o.pending = state_i.pending - u8d_pkg::LenW'(1);
        state_o.partial = shifted;
      end
    end else begin
      // Idle: classify the lead byte
      priority casez (byte_i)
        8'b0???????: begin
          res_o = '{valid: 1'b1, code: u8d_pkg::CodeW'(byte_i[6:0]),
                    len: u8d_pkg::LenW'(1), status: u8d_pkg::ST_OK};
        end
        8'b10??????: begin
          res_o = '{valid: 1'b1, code: '0, len: '0, status: u8d_pkg::ST_INVALID};
        end
        8'b110?????: begin
          state_o = '{pending: u8d_pkg::LenW'(1),
                      partial: u8d_pkg::CodeW'(byte_i[4:0]), total: u8d_pkg::LenW'(2)};
        end
        8'b1110????: begin
          state_o = '{pending: u8d_pkg::LenW'(2),
                      partial: u8d_pkg::CodeW'(byte_i[3:0]), total: u8d_pkg::LenW'(3)};
        end
        8'b11110???: begin
          state_o = '{pending: u8d_pkg::LenW'(3),
                      partial: u8d_pkg::CodeW'(byte_i[2:0]), total: u8d_pkg::LenW'(4)};
        end
        8'b111110??: begin
          state_o = '{pending: u8d_pkg::LenW'(4),
                      partial: u8d_pkg::CodeW'(byte_i[1:0]), total: u8d_pkg::LenW'(5)};
        end
        8'b1111110?: begin
          state_o = '{pending: u8d_pkg::LenW'(5),
                      partial: u8d_pkg::CodeW'(byte_i[0]), total: u8d_pkg::LenW'(6)};
        end
        default: begin
          // 0xFE / 0xFF lead
          res_o = '{valid: 1'b1, code: '0, len: '0, status: u8d_pkg::ST_INVALID};
        end
      endcase
    end
  end

endmodule

/* rtl/utf8_stream_decoder.sv */
// Top level: byte-serial six-byte UTF-8 decoder with input and result registers.
// A byte goes from the input register through the decode step to the result and out_.
// Throughput: one byte per cycle while the result register is not stalled; the input
// register feeds a single decode step whose result register frees when taken or empty.
// Reset (rst_n low, synchronous): sequence state cleared to idle, both stages empty.
`timescale 1ns / 1ps

module utf8_stream_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [u8d_pkg::ByteW-1:0]    in_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [u8d_pkg::CodeW-1:0]    out_code_point,
  output logic [u8d_pkg::LenW-1:0]     out_seq_length,
  output logic [1:0]                   out_status
);

  logic                       in_vld_r;
  logic [u8d_pkg::ByteW-1:0]  byte_r;
  u8d_pkg::dec_state_t        state_r;
  u8d_pkg::dec_state_t        state_nxt;
  u8d_pkg::dec_result_t       res_nxt;
  u8d_pkg::dec_result_t       out_r;
  logic                       out_free;
  logic                       advance;

  // Result register can take a new value when empty or being drained
  assign out_free = !out_r.valid || !out_stall;
  assign advance  = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_byte;
    end
  end

  // Decode step
  u8d_step u_step (
    .byte_i  (byte_r),
    .state_i (state_r),
    .state_o (state_nxt),
    .res_o   (res_nxt)
  );

  // Sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= u8d_pkg::StateIdle;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register: valid flag is reset, payload loads with each new result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (out_free) begin
      out_r.valid <= advance && res_nxt.valid;
    end
    if (advance && res_nxt.valid) begin
      out_r.code   <= res_nxt.code;
      out_r.len    <= res_nxt.len;
      out_r.status <= res_nxt.status;
    end
  end

  assign out_valid      = out_r.valid;
  assign out_code_point = out_r.code;
  assign out_seq_length = out_r.len;
  assign out_status     = out_r.status;

  // Error results carry no code and no length
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != u8d_pkg::ST_OK |-> out_code_point == '0 && out_seq_length == '0)
    else $error("error result with nonzero code or length");

  // Good results have a length from one to six
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == u8d_pkg::ST_OK |->
      out_seq_length != '0 && out_seq_length != 3'd7)
    else $error("ok result with bad length");

  // Pending count stays below the total length of the sequence
  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pending != '0 |-> state_r.pending < state_r.total && state_r.total <= 3'd6)
    else $error("pending count out of range");

  // Stall only comes from a held request behind a blocked result
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_valid && out_stall)
    else $error("input stalled without cause");

endmodule
